// ----- hdl/software_timer_table_top_defines.svh -----
// Assertion macros for the checker file of the software timer table.
`ifndef SOFTWARE_TIMER_TABLE_TOP_DEFINES_SVH
`define SOFTWARE_TIMER_TABLE_TOP_DEFINES_SVH

// Concurrent assertion sampled on the rising clock edge, disabled during reset.
`define STT_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion sampled on the rising clock edge at all times.
`define STT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/stt_pkg.sv -----
// Types, constants and controller/datapath structs of the software timer table.
package stt_pkg;

   localparam int SLOTS        = 16;
   localparam int SLOT_W       = $clog2(SLOTS);
   localparam int TIME_W       = 32;
   localparam int TASK_W       = 8;
   localparam int KIND_W       = 2;
   localparam int SLOT_FIELD_W = 4;

   localparam logic [TASK_W-1:0] STOP_TASK = '1;

   typedef enum logic [KIND_W-1:0] {
      KIND_CREATED = 2'd0,
      KIND_FIRED   = 2'd1,
      KIND_FULL    = 2'd2,
      KIND_DONE    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_CREATE_SEARCH,
      ST_SCAN_READ,
      ST_SCAN_EVAL,
      ST_DONE
   } state_type;

   // One timer slot as held in the slot memory.
   typedef struct packed {
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] interval;
      logic              rep_mode;
      logic [TASK_W-1:0] task_id;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic     load_req;
      logic     idx_clear;
      logic     idx_inc;
      logic     ram_rd;
      logic     wr_create;
      logic     wr_restart;
      logic     clear_valid;
      logic     emit;
      kind_type emit_kind;
   } cmd_type;

   typedef struct packed {
      logic action;
      logic cur_valid;
      logic due;
      logic is_stop;
      logic rep_mode;
      logic idx_last;
      logic out_free;
   } status_type;

endpackage

// ----- hdl/stt_if.sv -----
// Request and response channel interfaces of the software timer table.
interface stt_req_if;
   import stt_pkg::*;

   logic              valid;
   logic              ready;
   logic              action;
   logic [TIME_W-1:0] now_ms;
   logic [TIME_W-1:0] interval_ms;
   logic [TASK_W-1:0] task_id;
   logic              repeat_req;

   modport source (output valid, action, now_ms, interval_ms, task_id, repeat_req,
                   input ready);
   modport sink   (input valid, action, now_ms, interval_ms, task_id, repeat_req,
                   output ready);
endinterface

interface stt_rsp_if;
   import stt_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [KIND_W-1:0]       kind;
   logic [SLOT_FIELD_W-1:0] slot;
   logic [TASK_W-1:0]       fired_task;
   logic                    last;

   modport source (output valid, kind, slot, fired_task, last, input ready);
   modport sink   (input valid, kind, slot, fired_task, last, output ready);
endinterface

// ----- hdl/stt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module stt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/stt_datapath.sv -----
// Datapath: request latch, slot memory, valid bits, slot index and response register.
module stt_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  stt_pkg::cmd_type               cmd,
   output stt_pkg::status_type            status,
   input  logic                           req_action,
   input  logic [stt_pkg::TIME_W-1:0]     req_now_ms,
   input  logic [stt_pkg::TIME_W-1:0]     req_interval_ms,
   input  logic [stt_pkg::TASK_W-1:0]     req_task_id,
   input  logic                           req_repeat_req,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [stt_pkg::KIND_W-1:0]     rsp_kind,
   output logic [stt_pkg::SLOT_FIELD_W-1:0] rsp_slot,
   output logic [stt_pkg::TASK_W-1:0]     rsp_fired_task,
   output logic                           rsp_last
);
   import stt_pkg::*;

   // Latched request.
   logic              action_ff;
   logic [TIME_W-1:0] now_ff;
   logic [TIME_W-1:0] interval_ff;
   logic [TASK_W-1:0] task_ff;
   logic              rep_ff;

   logic [SLOTS-1:0]  valid_ff;
   logic [SLOT_W-1:0] idx_ff;

   // Response register.
   logic                    rsp_valid_ff;
   logic [KIND_W-1:0]       kind_ff;
   logic [SLOT_FIELD_W-1:0] slot_ff;
   logic [TASK_W-1:0]       fired_ff;
   logic                    last_ff;

   entry_type              rd_entry;
   entry_type              wr_entry;
   logic [ENTRY_W-1:0]     rd_data;
   logic                   wr_en;
   logic [TIME_W-1:0]      elapsed;
   logic [SLOT_W+SLOT_FIELD_W-1:0] slot_ext;
   logic                   out_free;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff   <= req_action;
         now_ff      <= req_now_ms;
         interval_ff <= req_interval_ms;
         task_ff     <= req_task_id;
         rep_ff      <= req_repeat_req;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.idx_clear) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wr_create) begin
         valid_ff[idx_ff] <= 1'b1;
      end else if (cmd.clear_valid) begin
         valid_ff[idx_ff] <= 1'b0;
      end
   end

   // A new timer takes the whole entry; a restart keeps all but the start time.
   always_comb begin
      if (cmd.wr_create) begin
         wr_entry.start_time = now_ff;
         wr_entry.interval   = interval_ff;
         wr_entry.rep_mode   = rep_ff;
         wr_entry.task_id    = task_ff;
      end else begin
         wr_entry            = rd_entry;
         wr_entry.start_time = now_ff;
      end
   end

   assign wr_en = cmd.wr_create || cmd.wr_restart;

   stt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff),
      .wr_data (wr_entry),
      .rd_en   (cmd.ram_rd),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign rd_entry = rd_data;
   assign elapsed  = now_ff - rd_entry.start_time;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign slot_ext = {{SLOT_FIELD_W{1'b0}}, idx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         kind_ff <= cmd.emit_kind;
         case (cmd.emit_kind)
            KIND_FIRED: begin
               slot_ff  <= slot_ext[SLOT_FIELD_W-1:0];
               fired_ff <= rd_entry.task_id;
               last_ff  <= 1'b0;
            end
            KIND_CREATED: begin
               slot_ff  <= slot_ext[SLOT_FIELD_W-1:0];
               fired_ff <= '0;
               last_ff  <= 1'b1;
            end
            default: begin
               slot_ff  <= '0;
               fired_ff <= '0;
               last_ff  <= 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      status.action    = action_ff;
      status.cur_valid = valid_ff[idx_ff];
      status.due       = elapsed >= rd_entry.interval;
      status.is_stop   = rd_entry.task_id == STOP_TASK;
      status.rep_mode  = rd_entry.rep_mode;
      status.idx_last  = idx_ff == SLOT_W'(SLOTS - 1);
      status.out_free  = out_free;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_slot       = slot_ff;
   assign rsp_fired_task = fired_ff;
   assign rsp_last       = last_ff;

endmodule

// ----- hdl/stt_ctrl.sv -----
// Controller state machine that sequences create searches and scans.
module stt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  stt_pkg::status_type status,
   output stt_pkg::cmd_type    cmd
);
   import stt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.emit_kind = KIND_DONE;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req  = 1'b1;
               cmd.idx_clear = 1'b1;
               state_in      = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = status.action ? ST_CREATE_SEARCH : ST_SCAN_READ;
         end
         ST_CREATE_SEARCH: begin
            if (!status.cur_valid) begin
               if (status.out_free) begin
                  cmd.wr_create = 1'b1;
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = KIND_CREATED;
                  state_in      = ST_IDLE;
               end
            end else if (status.idx_last) begin
               if (status.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = KIND_FULL;
                  state_in      = ST_IDLE;
               end
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_SCAN_READ: begin
            if (status.cur_valid) begin
               cmd.ram_rd = 1'b1;
               state_in   = ST_SCAN_EVAL;
            end else if (status.idx_last) begin
               state_in = ST_DONE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_SCAN_EVAL: begin
            if (status.due && status.is_stop) begin
               state_in = ST_DONE;
            end else if (!status.due || status.out_free) begin
               if (status.due) begin
                  cmd.emit        = 1'b1;
                  cmd.emit_kind   = KIND_FIRED;
                  cmd.wr_restart  = status.rep_mode;
                  cmd.clear_valid = !status.rep_mode;
               end
               if (status.idx_last) begin
                  state_in = ST_DONE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_SCAN_READ;
               end
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_DONE;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hdl/software_timer_table_top.sv -----
// Top level of the software timer table: controller, datapath and channel wiring.
//
// The software timer table holds SLOTS timer slots (16 by default) in a single
// slot memory with one write and one registered read port, plus one valid flip-flop
// per slot that reset clears, so the table comes up empty with no clearing pass.
// A create request takes the lowest free slot, stores the interval, task id and
// mode with the request's time as the start, and answers with one created
// response (or one table-full response). A scan request walks the slots in
// ascending order; every slot whose elapsed time modulo 2^32 has reached its
// interval produces a fired response with its task id, periodic slots restart at
// the scan time and one-shot slots are freed. A due slot holding the stop task id
// (all ones) ends the scan early without firing. Each scan closes with a done
// response, and last is set on the final response of every request.
// A request is taken in the idle state and dispatched in the cycle after. A create then
// tests one valid bit per cycle. A scan passes over each empty slot in its read state
// and handles each occupied slot in two steps (memory read, then the
// 32-bit elapsed-time subtract and compare), and ends with the done response.
// One request is in work at a time; the response register lets a new request be
// taken while the previous final response still waits, and a stalled response
// channel holds the sequence where it stands.
module software_timer_table_top (
   input logic        clock,
   input logic        reset,
   stt_req_if.sink    req_chan,
   stt_rsp_if.source  rsp_chan
);
   import stt_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   stt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   stt_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_action      (req_chan.action),
      .req_now_ms      (req_chan.now_ms),
      .req_interval_ms (req_chan.interval_ms),
      .req_task_id     (req_chan.task_id),
      .req_repeat_req  (req_chan.repeat_req),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_kind        (rsp_chan.kind),
      .rsp_slot        (rsp_chan.slot),
      .rsp_fired_task  (rsp_chan.fired_task),
      .rsp_last        (rsp_chan.last)
   );

   assign req_chan.ready = req_ready;

endmodule

// ----- hdl/stt_checker.sv -----
// Port-level checker of the software timer table and its bind to the top level.
`include "software_timer_table_top_defines.svh"

module stt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [stt_pkg::KIND_W-1:0]       rsp_kind,
   input logic [stt_pkg::SLOT_FIELD_W-1:0] rsp_slot,
   input logic [stt_pkg::TASK_W-1:0]       rsp_fired_task,
   input logic                             rsp_last
);
   import stt_pkg::*;

   // A stalled response keeps its content.
   `STT_ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_slot) && $stable(rsp_fired_task) && $stable(rsp_last), "response changed while stalled")

   // Only fired responses leave the request open.
   `STT_ASSERT_CLK(a_last_kind, clock, reset, rsp_valid |-> (rsp_last == (rsp_kind != KIND_FIRED)), "last does not match response kind")

   // Created, full and done responses carry no task id.
   `STT_ASSERT_CLK(a_task_zero, clock, reset, rsp_valid && rsp_kind != KIND_FIRED |-> rsp_fired_task == '0, "task id on a non-fired response")

   // One request in work at a time: no new request right after one is taken.
   `STT_ASSERT_CLK(a_one_request, clock, reset, req_valid && req_ready |=> !req_ready, "request taken while another is in work")

endmodule

bind software_timer_table_top stt_checker u_stt_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_kind       (rsp_chan.kind),
   .rsp_slot       (rsp_chan.slot),
   .rsp_fired_task (rsp_chan.fired_task),
   .rsp_last       (rsp_chan.last)
);

// ----- dv/stt_tb_pkg.sv -----
// Request and response records and the scoreboard class of the software timer table testbench.
package stt_tb_pkg;
   import stt_pkg::*;

   localparam logic ACTION_SCAN   = 1'b0;
   localparam logic ACTION_CREATE = 1'b1;

   // Above this interval a one-shot timer will in practice never expire during a run.
   localparam logic [TIME_W-1:0] LONG_INTERVAL = 32'h0100_0000;

   typedef struct {
      logic              action;
      logic [TIME_W-1:0] now_ms;
      logic [TIME_W-1:0] interval_ms;
      logic [TASK_W-1:0] task_id;
      logic              repeat_req;
   } timer_request_type;

   typedef struct {
      kind_type                kind;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [TASK_W-1:0]       fired_task;
      logic                    last;
   } timer_response_type;

   class timer_table_scoreboard;
      bit                 slot_busy[SLOTS];
      logic [TIME_W-1:0]  started_at[SLOTS];
      logic [TIME_W-1:0]  period[SLOTS];
      bit                 periodic[SLOTS];
      logic [TASK_W-1:0]  owner_task[SLOTS];
      timer_response_type awaited[$];
      int unsigned        mismatches;

      function new();
         foreach (slot_busy[i]) slot_busy[i] = 1'b0;
         mismatches = 0;
      endfunction

      function void queue_result(kind_type kind, int slot_num, logic [TASK_W-1:0] tid,
                                 logic last);
         timer_response_type r;
         r.kind       = kind;
         r.slot       = SLOT_FIELD_W'(slot_num);
         r.fired_task = tid;
         r.last       = last;
         awaited.push_back(r);
      endfunction

      // Applies one accepted request to the table copy and queues its responses.
      function void note_request(timer_request_type req);
         int                i;
         logic [TIME_W-1:0] elapsed;
         if (req.action == ACTION_CREATE) begin
            for (i = 0; i < SLOTS; i++)
               if (!slot_busy[i]) break;
            if (i == SLOTS) begin
               queue_result(KIND_FULL, 0, '0, 1'b1);
            end else begin
               slot_busy[i]  = 1'b1;
               started_at[i] = req.now_ms;
               period[i]     = req.interval_ms;
               periodic[i]   = req.repeat_req;
               owner_task[i] = req.task_id;
               queue_result(KIND_CREATED, i, '0, 1'b1);
            end
            return;
         end
         for (i = 0; i < SLOTS; i++) begin
            if (!slot_busy[i]) continue;
            elapsed = req.now_ms - started_at[i];
            if (elapsed < period[i]) continue;
            // A due stop marker ends the walk; the slot stays as it is.
            if (owner_task[i] == STOP_TASK) break;
            queue_result(KIND_FIRED, i, owner_task[i], 1'b0);
            if (periodic[i]) started_at[i] = req.now_ms;
            else slot_busy[i] = 1'b0;
         end
         queue_result(KIND_DONE, 0, '0, 1'b1);
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
      endtask

      task check_response(timer_response_type got);
         timer_response_type want;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected response kind=%0d slot=%0d task=%0d last=%0d",
                             got.kind, got.slot, got.fired_task, got.last));
            return;
         end
         want = awaited.pop_front();
         if (got.kind !== want.kind)
            report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
         if (got.slot !== want.slot)
            report($sformatf("slot %0d, expected %0d", got.slot, want.slot));
         if (got.fired_task !== want.fired_task)
            report($sformatf("fired_task %0d, expected %0d", got.fired_task, want.fired_task));
         if (got.last !== want.last)
            report($sformatf("last %0d, expected %0d", got.last, want.last));
      endtask

      function int unsigned pending();
         return awaited.size();
      endfunction

      // Slots that will in practice stay occupied: periodic timers, stop markers
      // and one-shot timers with very long intervals.
      function int unsigned held_slots();
         int unsigned n;
         n = 0;
         foreach (slot_busy[i])
            if (slot_busy[i] && (periodic[i] || owner_task[i] == STOP_TASK ||
                                 period[i] > LONG_INTERVAL))
               n++;
         return n;
      endfunction
   endclass

endpackage

// ----- dv/software_timer_table_top_tb.sv -----
// Top-level testbench of the software timer table: stimulus, stalls, checking and end of run.
module software_timer_table_top_tb;
   import stt_pkg::*;
   import stt_tb_pkg::*;

   // The drain window at the end outlasts a full-table scan in the block with some margin.
   // The cycle limit is far above the slowest correct run, where every response waits
   // out a heavy stall pattern.
   localparam int          DRAIN_CYCLES    = 2 * SLOTS + 8;
   localparam int unsigned CYCLE_LIMIT     = 500_000;
   localparam int          RANDOM_REQUESTS = 220;

   typedef enum {STALL_NONE, STALL_HALF, STALL_LIGHT, STALL_HEAVY} stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   stt_req_if req_chan();
   stt_rsp_if rsp_chan();

   software_timer_table_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   timer_table_scoreboard timers = new();

   int unsigned        cycle_count = 0;
   int unsigned        burst_left  = 0;
   int unsigned        stall_left  = 0;
   stall_mode_type     stall_mode  = STALL_NONE;
   timer_response_type seen_rsp;
   logic [TIME_W-1:0]  wall_ms;

   always #4 clock = ~clock;

   // The receiver changes its stall behavior after a random stretch: sometimes it
   // is always ready, sometimes it stalls lightly, half the time or most of the time.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE:  rsp_chan.ready <= 1'b1;
         STALL_HALF:  rsp_chan.ready <= ($urandom_range(0, 1) == 1);
         STALL_LIGHT: rsp_chan.ready <= ($urandom_range(0, 7) != 0);
         default:     rsp_chan.ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   // Response monitor and watchdog. Values read here are those from before the
   // edge, since the block and the drivers only update through nonblocking writes.
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         seen_rsp.kind       = kind_type'(rsp_chan.kind);
         seen_rsp.slot       = rsp_chan.slot;
         seen_rsp.fired_task = rsp_chan.fired_task;
         seen_rsp.last       = rsp_chan.last;
         timers.check_response(seen_rsp);
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic timer_request_type request_of(logic action, logic [TIME_W-1:0] now,
                                                    logic [TIME_W-1:0] ivl,
                                                    logic [TASK_W-1:0] tid, logic rep);
      timer_request_type r;
      r.action      = action;
      r.now_ms      = now;
      r.interval_ms = ivl;
      r.task_id     = tid;
      r.repeat_req  = rep;
      return r;
   endfunction

   // A scan at the given time; the fields that a scan ignores carry random values.
   function automatic timer_request_type scan_request(logic [TIME_W-1:0] now);
      return request_of(ACTION_SCAN, now, $urandom(), TASK_W'($urandom()), 1'($urandom()));
   endfunction

   // Presents one request and returns at the edge where it is taken. Requests go
   // out in bursts; between bursts the sender usually pauses for a random gap, and
   // sometimes goes straight on so that long stretches have no idle cycle at all.
   // Called at a rising edge; valid is only lowered when a gap really follows.
   task automatic issue_request(input timer_request_type r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid       <= 1'b1;
      req_chan.action      <= r.action;
      req_chan.now_ms      <= r.now_ms;
      req_chan.interval_ms <= r.interval_ms;
      req_chan.task_id     <= r.task_id;
      req_chan.repeat_req  <= r.repeat_req;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      timers.note_request(r);
   endtask

   initial begin
      timer_request_type r;
      int                n;
      int                create_pct;
      int                pick;
      bit                may_hold;

      req_chan.valid       <= 1'b0;
      req_chan.action      <= ACTION_SCAN;
      req_chan.now_ms      <= '0;
      req_chan.interval_ms <= '0;
      req_chan.task_id     <= '0;
      req_chan.repeat_req  <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A scan of the empty table answers with done alone.
      issue_request(scan_request(32'h0));
      // Zero-interval one-shot in slot 0, a stop marker with the largest interval in
      // slot 1 (due only one millisecond before its start comes round again) and a
      // periodic timer in slot 2 whose start lies just before the time wraps.
      issue_request(request_of(ACTION_CREATE, 32'h0, 32'h0, 8'h00, 1'b0));
      issue_request(request_of(ACTION_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, STOP_TASK, 1'b1));
      issue_request(request_of(ACTION_CREATE, 32'hFFFF_FFF0, 32'h20, 8'hFE, 1'b1));
      // Slot 0 fires and is freed; the stop marker and slot 2 are not yet due.
      issue_request(scan_request(32'h8));
      // Slot 2 becomes due across the wrap and restarts at this time.
      issue_request(scan_request(32'h10));
      // Slot 0 is reused; slot 3 gets a periodic timer that is due on every scan.
      issue_request(request_of(ACTION_CREATE, 32'h10, 32'h5, 8'h5A, 1'b0));
      issue_request(request_of(ACTION_CREATE, 32'h10, 32'h0, 8'hA5, 1'b1));
      issue_request(scan_request(32'h15));
      // Slot 0 fires ahead of the due stop marker in slot 1, which then cuts the
      // scan short: slot 3 is due but is never reached.
      issue_request(request_of(ACTION_CREATE, 32'h20, 32'h3, 8'h11, 1'b0));
      issue_request(scan_request(32'hFFFF_FFFE));
      issue_request(scan_request(32'hFFFF_FFFE));
      // A stop marker that is not due is passed over like any other waiting slot.
      issue_request(request_of(ACTION_CREATE, 32'h30, 32'hFFFF_FFF0, STOP_TASK, 1'b0));
      issue_request(scan_request(32'h40));

      // Random part, in episodes that lean toward scans, a mix, or creates; the
      // create-heavy episodes fill the table so that table-full answers appear.
      // Time mostly moves forward in small steps from just below the wrap, with an
      // occasional jump anywhere. Timers that would hold a slot for good (periodic,
      // stop markers, very long intervals) are only made while few slots are held.
      wall_ms = 32'hFFFF_F000;
      create_pct = 50;
      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 20 == 0) begin
            pick = $urandom_range(0, 2);
            create_pct = (pick == 0) ? 20 : (pick == 1) ? 50 : 90;
         end
         if ($urandom_range(0, 99) == 0) wall_ms = $urandom();
         else wall_ms += $urandom_range(0, 1500);
         r = scan_request(wall_ms);
         if ($urandom_range(0, 99) < create_pct) begin
            r.action = ACTION_CREATE;
            may_hold = (timers.held_slots() < 10);
            pick = $urandom_range(0, 99);
            if (pick < 70) r.interval_ms = $urandom_range(0, 3000);
            else if (pick < 90) r.interval_ms = $urandom_range(0, 100_000);
            else if (pick < 95) r.interval_ms = '0;
            else if (!may_hold) r.interval_ms = $urandom_range(0, 3000);
            if (may_hold && $urandom_range(0, 99) < 3) r.task_id = STOP_TASK;
            else r.task_id = TASK_W'($urandom_range(0, 254));
            r.repeat_req = may_hold && ($urandom_range(0, 3) == 0);
         end
         issue_request(r);
      end

      req_chan.valid <= 1'b0;
      while (timers.pending() != 0) @(posedge clock);
      // Any stray response after the last expected one is caught in this window.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (timers.mismatches == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
